/* hdl/number_to_word_tokens_assert.svh */
// assertion macros for number_to_word_tokens
`ifndef NUMBER_TO_WORD_TOKENS_ASSERT_SVH
`define NUMBER_TO_WORD_TOKENS_ASSERT_SVH

// same-cycle implication, checked out of reset
`define N2W_ASSERT_NOW(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("number_to_word_tokens: same-cycle check failed");

// next-cycle implication, checked out of reset
`define N2W_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("number_to_word_tokens: next-cycle check failed");

`endif

/* hdl/n2w_pkg.sv */
// package: widths, token codes and microcode types for number_to_word_tokens
`default_nettype none
package n2w_pkg;

	localparam int NUMBER_W = 31;
	localparam int CODE_W = 5;
	localparam int DIGIT_W = 4;
	localparam int DIGITS = 10;
	localparam int BCD_W = DIGITS * DIGIT_W;
	localparam int CNT_W = 5;
	localparam int GRP_W = 2;

	// one dabble step per input bit
	localparam logic [CNT_W-1:0] DABBLE_LAST = CNT_W'(NUMBER_W - 1);

	// token codes
	localparam logic [CODE_W-1:0] CODE_ZERO = 5'd0;
	localparam logic [CODE_W-1:0] CODE_TEEN_BASE = 5'd10;
	localparam logic [CODE_W-1:0] CODE_TENS_BASE = 5'd18;
	localparam logic [CODE_W-1:0] CODE_HUNDRED = 5'd28;
	localparam logic [CODE_W-1:0] CODE_SCALE_BASE = 5'd28;

	localparam logic [GRP_W-1:0] GRP_TOP = 2'd3;
	localparam logic [GRP_W-1:0] GRP_UNITS = 2'd0;

	// microprogram step addresses
	typedef enum logic [4:0] {
		STEP_WAIT   = 5'd0,
		STEP_CONV   = 5'd1,
		STEP_ZCHK   = 5'd2,
		STEP_GCHK   = 5'd3,
		STEP_HCHK   = 5'd4,
		STEP_HDIG   = 5'd5,
		STEP_HWORD  = 5'd6,
		STEP_RCHK   = 5'd7,
		STEP_TCHK   = 5'd8,
		STEP_TENS   = 5'd9,
		STEP_ONES   = 5'd10,
		STEP_TEEN   = 5'd11,
		STEP_SCHK   = 5'd12,
		STEP_SCALE  = 5'd13,
		STEP_NXT    = 5'd14,
		STEP_LOOP   = 5'd15,
		STEP_EZERO  = 5'd16
	} step_t;

	// jump conditions
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_IN_IDLE,
		C_CNT_NZ,
		C_BCD_ZERO,
		C_GRP_ZERO,
		C_H_ZERO,
		C_REST_ZERO,
		C_T_LT2,
		C_O_ZERO,
		C_G_ZERO
	} cond_t;

	// datapath actions
	typedef enum logic [2:0] {
		A_NONE,
		A_LOAD,
		A_DABBLE,
		A_GSET,
		A_GDEC
	} act_t;

	// token code source
	typedef enum logic [2:0] {
		SRC_HDIG,
		SRC_HUNDRED,
		SRC_TENS,
		SRC_ONES,
		SRC_TEEN,
		SRC_SCALE,
		SRC_ZERO
	} src_t;

	// rule for the last-token marker
	typedef enum logic [2:0] {
		L_NONE,
		L_ONE,
		L_REST0_G0,
		L_O0_G0,
		L_G0,
		L_LOWER0
	} last_t;

	typedef struct packed {
		step_t target;
		cond_t cond;
		act_t  act;
		logic  emit;
		src_t  src;
		last_t last;
	} cw_t;

	typedef struct packed {
		act_t act;
		src_t src;
	} dp_ctrl_t;

	typedef struct packed {
		logic cnt_nz;
		logic bcd_zero;
		logic grp_zero;
		logic h_zero;
		logic rest_zero;
		logic t_lt2;
		logic o_zero;
		logic g_zero;
		logic lower_zero;
	} dp_flags_t;

endpackage
`default_nettype wire

/* hdl/n2w_in_if.sv */
// input channel: one number per request
`default_nettype none
interface n2w_in_if import n2w_pkg::*;;
	logic                valid;
	logic                ready;
	logic [NUMBER_W-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink (input valid, input number, output ready);
endinterface
`default_nettype wire

/* hdl/n2w_out_if.sv */
// output channel: one word token per request
`default_nettype none
interface n2w_out_if import n2w_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] word_code;
	logic              last_word;

	modport source (output valid, output word_code, output last_word, input ready);
	modport sink (input valid, input word_code, input last_word, output ready);
endinterface
`default_nettype wire

/* hdl/n2w_ucode_rom.sv */
// microprogram rom: one control word per step
`default_nettype none
module n2w_ucode_rom import n2w_pkg::*; (
	input  step_t step,
	output cw_t   cw
);

	// program: convert, then spell zero or walk groups from billions down to units
	always_comb begin
		cw = '{target: STEP_WAIT, cond: C_NEVER, act: A_NONE, emit: 1'b0,
			src: SRC_ZERO, last: L_NONE};
		case (step)
			STEP_WAIT: begin
				cw.cond = C_IN_IDLE; cw.target = STEP_WAIT; cw.act = A_LOAD;
			end
			STEP_CONV: begin
				cw.cond = C_CNT_NZ; cw.target = STEP_CONV; cw.act = A_DABBLE;
			end
			STEP_ZCHK: begin
				cw.cond = C_BCD_ZERO; cw.target = STEP_EZERO; cw.act = A_GSET;
			end
			STEP_GCHK: begin
				cw.cond = C_GRP_ZERO; cw.target = STEP_NXT;
			end
			STEP_HCHK: begin
				cw.cond = C_H_ZERO; cw.target = STEP_RCHK;
			end
			STEP_HDIG: begin
				cw.emit = 1'b1; cw.src = SRC_HDIG; cw.last = L_NONE;
			end
			STEP_HWORD: begin
				cw.emit = 1'b1; cw.src = SRC_HUNDRED; cw.last = L_REST0_G0;
			end
			STEP_RCHK: begin
				cw.cond = C_REST_ZERO; cw.target = STEP_SCHK;
			end
			STEP_TCHK: begin
				cw.cond = C_T_LT2; cw.target = STEP_TEEN;
			end
			STEP_TENS: begin
				cw.emit = 1'b1; cw.src = SRC_TENS; cw.last = L_O0_G0;
				cw.cond = C_O_ZERO; cw.target = STEP_SCHK;
			end
			STEP_ONES: begin
				cw.emit = 1'b1; cw.src = SRC_ONES; cw.last = L_G0;
				cw.cond = C_ALWAYS; cw.target = STEP_SCHK;
			end
			STEP_TEEN: begin
				cw.emit = 1'b1; cw.src = SRC_TEEN; cw.last = L_G0;
			end
			STEP_SCHK: begin
				cw.cond = C_G_ZERO; cw.target = STEP_NXT;
			end
			STEP_SCALE: begin
				cw.emit = 1'b1; cw.src = SRC_SCALE; cw.last = L_LOWER0;
			end
			STEP_NXT: begin
				cw.cond = C_G_ZERO; cw.target = STEP_WAIT; cw.act = A_GDEC;
			end
			STEP_LOOP: begin
				cw.cond = C_ALWAYS; cw.target = STEP_GCHK;
			end
			STEP_EZERO: begin
				cw.emit = 1'b1; cw.src = SRC_ZERO; cw.last = L_ONE;
				cw.cond = C_ALWAYS; cw.target = STEP_WAIT;
			end
			default: begin
				cw.cond = C_ALWAYS; cw.target = STEP_WAIT;
			end
		endcase
	end

endmodule
`default_nettype wire

/* hdl/n2w_datapath.sv */
// datapath: double-dabble converter, group pointer and token code mux
`default_nettype none
module n2w_datapath import n2w_pkg::*; (
	input  wire logic                clk,
	input  wire dp_ctrl_t            ctrl,
	input  wire logic [NUMBER_W-1:0] number,
	output dp_flags_t                flags,
	output logic [CODE_W-1:0]        code
);

	logic [NUMBER_W-1:0] bin_q;
	logic [BCD_W-1:0]    bcd_q;
	logic [BCD_W-1:0]    bcd_adj;
	logic [CNT_W-1:0]    cnt_q;
	logic [GRP_W-1:0]    g_q;
	logic [DIGIT_W-1:0]  h_dig;
	logic [DIGIT_W-1:0]  t_dig;
	logic [DIGIT_W-1:0]  o_dig;
	logic                lower_zero;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + 4'd3;
			end else begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (ctrl.act)
			A_LOAD: begin
				bin_q <= number;
				bcd_q <= '0;
				cnt_q <= DABBLE_LAST;
			end
			A_DABBLE: begin
				bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[NUMBER_W-1]};
				bin_q <= {bin_q[NUMBER_W-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
			end
			A_GSET: begin
				g_q <= GRP_TOP;
			end
			A_GDEC: begin
				g_q <= g_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	// digits of the current three-digit group
	always_comb begin
		case (g_q)
			2'd3: begin
				h_dig = '0;
				t_dig = '0;
				o_dig = bcd_q[39:36];
				lower_zero = (bcd_q[35:0] == '0);
			end
			2'd2: begin
				h_dig = bcd_q[35:32];
				t_dig = bcd_q[31:28];
				o_dig = bcd_q[27:24];
				lower_zero = (bcd_q[23:0] == '0);
			end
			2'd1: begin
				h_dig = bcd_q[23:20];
				t_dig = bcd_q[19:16];
				o_dig = bcd_q[15:12];
				lower_zero = (bcd_q[11:0] == '0);
			end
			default: begin
				h_dig = bcd_q[11:8];
				t_dig = bcd_q[7:4];
				o_dig = bcd_q[3:0];
				lower_zero = 1'b1;
			end
		endcase
	end

	// status back to the sequencer
	always_comb begin
		flags.cnt_nz     = (cnt_q != '0);
		flags.bcd_zero   = (bcd_q == '0);
		flags.grp_zero   = ({h_dig, t_dig, o_dig} == '0);
		flags.h_zero     = (h_dig == '0);
		flags.rest_zero  = ({t_dig, o_dig} == '0);
		flags.t_lt2      = (t_dig < 4'd2);
		flags.o_zero     = (o_dig == '0);
		flags.g_zero     = (g_q == GRP_UNITS);
		flags.lower_zero = lower_zero;
	end

	// token code selection
	always_comb begin
		case (ctrl.src)
			SRC_HDIG:    code = {1'b0, h_dig};
			SRC_HUNDRED: code = CODE_HUNDRED;
			SRC_TENS:    code = CODE_TENS_BASE + {1'b0, t_dig};
			SRC_ONES:    code = {1'b0, o_dig};
			SRC_TEEN:    code = t_dig[0] ? CODE_TEEN_BASE + {1'b0, o_dig} : {1'b0, o_dig};
			SRC_SCALE:   code = CODE_SCALE_BASE + {3'b000, g_q};
			default:     code = CODE_ZERO;
		endcase
	end

endmodule
`default_nettype wire

/* hdl/number_to_word_tokens.sv */
// number_to_word_tokens: spells a 31-bit number as a run of english word tokens
//
// number_ch takes one number per request; word_ch gives one token per request,
// most significant word first, with last_word high on the final token.
// A microprogram counter steps through a small rom; each control word drives
// the converter datapath, optionally emits a token and optionally jumps.
// After a number is taken, 31 double-dabble steps turn it into ten bcd
// digits; the program then walks the billions, millions, thousands and units
// groups. The time one number occupies the block is set by the 31 conversion
// steps, the group walk and any stalls on word_ch.
// number_ch.ready is high only while the program waits at its first step;
// one number is handled at a time.
// Tokens leave through an output register: the program moves on while a token
// waits, and stalls at the next emitting step until word_ch takes the token.
// Reset returns the program to its waiting step and empties the output register.
`default_nettype none
module number_to_word_tokens import n2w_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	n2w_in_if.sink    number_ch,
	n2w_out_if.source word_ch
);

	step_t             step_q;
	step_t             step_nxt;
	cw_t               cw;
	dp_ctrl_t          dp_ctrl;
	dp_flags_t         flags;
	logic [CODE_W-1:0] code;
	logic              cond_true;
	logic              out_free;
	logic              stall;
	logic              fire;
	logic              last_now;
	logic              out_valid_q;
	logic [CODE_W-1:0] out_code_q;
	logic              out_last_q;

	n2w_ucode_rom u_rom (
		.step (step_q),
		.cw   (cw)
	);

	n2w_datapath u_dp (
		.clk    (clk),
		.ctrl   (dp_ctrl),
		.number (number_ch.number),
		.flags  (flags),
		.code   (code)
	);

	// jump condition select
	always_comb begin
		case (cw.cond)
			C_NEVER:     cond_true = 1'b0;
			C_ALWAYS:    cond_true = 1'b1;
			C_IN_IDLE:   cond_true = !number_ch.valid;
			C_CNT_NZ:    cond_true = flags.cnt_nz;
			C_BCD_ZERO:  cond_true = flags.bcd_zero;
			C_GRP_ZERO:  cond_true = flags.grp_zero;
			C_H_ZERO:    cond_true = flags.h_zero;
			C_REST_ZERO: cond_true = flags.rest_zero;
			C_T_LT2:     cond_true = flags.t_lt2;
			C_O_ZERO:    cond_true = flags.o_zero;
			C_G_ZERO:    cond_true = flags.g_zero;
			default:     cond_true = 1'b0;
		endcase
	end

	// last-token rule select
	always_comb begin
		case (cw.last)
			L_NONE:     last_now = 1'b0;
			L_ONE:      last_now = 1'b1;
			L_REST0_G0: last_now = flags.rest_zero && flags.g_zero;
			L_O0_G0:    last_now = flags.o_zero && flags.g_zero;
			L_G0:       last_now = flags.g_zero;
			L_LOWER0:   last_now = flags.lower_zero;
			default:    last_now = 1'b0;
		endcase
	end

	// sequencing: emitting steps hold while the output register is occupied and word_ch is not ready
	always_comb begin
		out_free = !out_valid_q || word_ch.ready;
		stall    = cw.emit && !out_free;
		fire     = cw.emit && out_free;
		if (stall) begin
			step_nxt = step_q;
		end else if (cond_true) begin
			step_nxt = cw.target;
		end else begin
			step_nxt = step_t'(step_q + 5'd1);
		end
		dp_ctrl.src = cw.src;
		if (stall || (cw.act == A_LOAD && !number_ch.valid)) begin
			dp_ctrl.act = A_NONE;
		end else begin
			dp_ctrl.act = cw.act;
		end
		number_ch.ready = (step_q == STEP_WAIT);
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
		end else begin
			step_q <= step_nxt;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (word_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			out_code_q <= code;
			out_last_q <= last_now;
		end
	end

	assign word_ch.valid     = out_valid_q;
	assign word_ch.word_code = out_code_q;
	assign word_ch.last_word = out_last_q;

`include "number_to_word_tokens_assert.svh"

	// a taken number always starts the conversion loop
	`N2W_ASSERT_NEXT(a_accept_to_conv, clk, arst_n,
		number_ch.valid && number_ch.ready, step_q == STEP_CONV)

	// an emitting step waits while a token is held back
	`N2W_ASSERT_NEXT(a_stall_holds, clk, arst_n,
		cw.emit && out_valid_q && !word_ch.ready, $stable(step_q) && out_valid_q)

	// a new number is only taken outside token emission
	`N2W_ASSERT_NOW(a_ready_no_emit, clk, arst_n, number_ch.ready, !cw.emit)

endmodule
`default_nettype wire

/* sim/tb.sv */
// scoreboard package and top-level testbench for number_to_word_tokens
package n2w_tb_pkg;
	import n2w_pkg::*;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              last;
	} word_token_t;

	class token_scoreboard;
		word_token_t spelled_words[$];
		int          errors;

		function new();
			errors = 0;
		endfunction

		function void push_word(logic [CODE_W-1:0] code);
			spelled_words.push_back({code, 1'b0});
		endfunction

		// spell one accepted number, billions group first
		function void note_number(logic [NUMBER_W-1:0] number);
			int unsigned groups [4];
			int unsigned remaining;
			int unsigned hund;
			int unsigned tail;
			remaining = number;
			if (remaining == 0) begin
				push_word(CODE_ZERO);
			end else begin
				for (int g = 0; g < 4; g++) begin
					groups[g] = remaining % 1000;
					remaining = remaining / 1000;
				end
				for (int g = 3; g >= 0; g--) begin
					hund = groups[g] / 100;
					tail = groups[g] % 100;
					if (groups[g] != 0) begin
						if (hund != 0) begin
							push_word(CODE_W'(hund));
							push_word(CODE_HUNDRED);
						end
						// tens word plus optional ones word, or a single word up to nineteen
						if (tail >= 20) begin
							push_word(CODE_W'(CODE_TENS_BASE + tail / 10));
							if (tail % 10 != 0)
								push_word(CODE_W'(tail % 10));
						end else if (tail != 0) begin
							push_word(CODE_W'(tail));
						end
						// units group carries no scale word
						if (g != 0)
							push_word(CODE_W'(CODE_SCALE_BASE + g));
					end
				end
			end
			spelled_words[spelled_words.size() - 1].last = 1'b1;
		endfunction

		// compare one token taken from the block with the oldest spelled word
		function void check_token(logic [CODE_W-1:0] code, logic last);
			word_token_t want;
			if (spelled_words.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected token: code %0d last %0b", code, last);
				return;
			end
			want = spelled_words.pop_front();
			if (want.code !== code || want.last !== last) begin
				errors++;
				if (errors <= 10)
					$display("token mismatch: expected code %0d last %0b, got code %0d last %0b",
						want.code, want.last, code, last);
			end
		endfunction
	endclass
endpackage

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import n2w_pkg::*;
	import n2w_tb_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_NUMBERS = 125;
	localparam int CALM_TAIL = 30;
	localparam longint unsigned MAX_NUMBER = 64'd2147483647;

	logic clk = 1'b0;
	logic arst_n;
	bit   sender_idles;
	bit   sink_idles;
	bit   hold_off_due;
	int   cycle_count;

	token_scoreboard board;

	n2w_in_if  number_ch ();
	n2w_out_if word_ch ();

	number_to_word_tokens uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.number_ch (number_ch),
		.word_ch   (word_ch)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// numbers with zero groups, teens, round hundreds and full-width values
	function automatic logic [NUMBER_W-1:0] pick_number();
		longint unsigned total;
		int unsigned     grp;
		total = 0;
		case ($urandom_range(0, 3))
			0: total = $urandom & MAX_NUMBER;
			1: total = $urandom_range(0, 999);
			default: begin
				for (int g = 0; g < 4; g++) begin
					case ($urandom_range(0, 3))
						0: grp = 0;
						1: grp = $urandom_range(1, 19);
						2: grp = $urandom_range(1, 9) * 100;
						default: grp = $urandom_range(0, 999);
					endcase
					if (g == 0)
						grp = grp % 3;
					total = total * 1000 + grp;
				end
				if (total > MAX_NUMBER)
					total = total - 1000000000;
			end
		endcase
		return NUMBER_W'(total);
	endfunction

	// offer one number, called and returning at a falling edge
	task automatic send_number(input logic [NUMBER_W-1:0] number);
		int gap;
		gap = (sender_idles && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
		if (gap > 0) begin
			number_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		number_ch.valid <= 1'b1;
		number_ch.number <= number;
		do
			@(posedge clk);
		while (!number_ch.ready);
		board.note_number(number);
		@(negedge clk);
	endtask

	// token receiver: random stall bursts and one long hold-off
	initial begin : word_sink
		int stall;
		word_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_due) begin
				hold_off_due = 1'b0;
				word_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
			end else if (sink_idles && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 7);
				word_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end else begin
				word_ch.ready <= 1'b1;
			end
		end
	end

	// check every token taken from the block
	always @(posedge clk) begin
		if (arst_n && word_ch.valid && word_ch.ready)
			board.check_token(word_ch.word_code, word_ch.last_word);
	end

	// run limit
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// reset, directed numbers, random numbers, then drain
	initial begin : stimulus
		logic [NUMBER_W-1:0] directed [$];
		board = new();
		arst_n = 1'b0;
		number_ch.valid = 1'b0;
		number_ch.number = '0;
		sender_idles = 1'b0;
		sink_idles = 1'b0;
		hold_off_due = 1'b0;
		directed = '{0, 1, 9, 10, 11, 19, 20, 21, 90, 99, 100, 101, 110, 115, 999, 1000,
			1001, 12345, 100000, 1000010, 1000000, 1000000000, 1234567891, 2000000000,
			2147483647};
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed numbers with idling on both sides
		sender_idles = 1'b1;
		sink_idles = 1'b1;
		foreach (directed[i])
			send_number(directed[i]);

		// random numbers, opened by a long hold-off on the token side
		hold_off_due = 1'b1;
		for (int i = 0; i < RANDOM_NUMBERS; i++) begin
			if (i >= RANDOM_NUMBERS - CALM_TAIL) begin
				sender_idles = 1'b0;
				sink_idles = 1'b0;
			end else if (i % 20 == 0) begin
				sender_idles = $urandom_range(0, 3) != 0;
				sink_idles = $urandom_range(0, 3) != 0;
			end
			send_number(pick_number());
		end
		number_ch.valid <= 1'b0;

		// wait for every spelled word, then let the block settle
		while (board.spelled_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
